// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Property checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- design/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types, operation codes and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int MAG_W = 64;
    localparam int DEN_W = 62;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [61:0]        res_den;
        logic               less_than;
        logic [1:0]         status;
    } t_out_item;

    // classified work handed from front to back
    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  nmag;
        logic [MAG_W-1:0]  dmag;
        logic              lt;
        logic [1:0]        status;
    } t_job;
endpackage

// ----- design/rau_front.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic front end
// Takes operand beats, forms cross products over stages, classifies.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rau_front #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rau_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_job_valid,
    output rau_pkg::t_job     o_job,
    input  logic              i_job_ready
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [2:0]       r_op;
    logic             r_sa, r_sb, r_zd;
    logic [W-1:0]     r_am, r_bm, r_adm, r_bdm;
    logic [MAG_W-1:0] r_p0, r_p1, r_p2;
    t_job             r_job, n_job;

    function automatic logic [W:0] take(input logic [31:0] raw);
        logic [W-1:0] v;
        logic [W-1:0] m;
        v = raw[W-1:0];
        m = v[W-1] ? (~v + 1'b1) : v;
        return {v[W-1], m};
    endfunction

    logic [W:0] w_an, w_ad, w_bn, w_bd;
    assign w_an = take(i_item.a_num);
    assign w_ad = take(i_item.a_den);
    assign w_bn = take(i_item.b_num);
    assign w_bd = take(i_item.b_den);

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op  <= i_item.opcode;
            r_am  <= w_an[W-1:0];
            r_bm  <= w_bn[W-1:0];
            r_adm <= w_ad[W-1:0];
            r_bdm <= w_bd[W-1:0];
            r_sa  <= (w_an[W] != w_ad[W]) && (w_an[W-1:0] != '0);
            r_sb  <= (w_bn[W] != w_bd[W]) && (w_bn[W-1:0] != '0);
            r_zd  <= (w_ad[W-1:0] == '0) || (w_bd[W-1:0] == '0);
        end
        if (r_state == S_MUL) begin
            unique case (r_op)
                OP_MUL: begin
                    r_p0 <= MAG_W'(r_am * r_bm);
                    r_p1 <= '0;
                end
                OP_DIV: begin
                    r_p0 <= MAG_W'(r_am * r_bdm);
                    r_p1 <= '0;
                end
                default: begin
                    r_p0 <= MAG_W'(r_am * r_bdm);
                    r_p1 <= MAG_W'(r_bm * r_adm);
                end
            endcase
            r_p2 <= (r_op == OP_DIV) ? MAG_W'(r_adm * r_bm) : MAG_W'(r_adm * r_bdm);
        end
        if (r_state == S_SUM) r_job <= n_job;
    end

    logic w_yneg;
    assign w_yneg = (r_op == OP_SUB) ? !(r_sb || r_bm == '0) && (r_bm != '0) : r_sb;

    always_comb begin
        n_job = '0;
        n_job.dmag = r_p2;
        priority if (r_zd) begin
            n_job.status = ST_ZERO_DEN;
        end else if (r_op == OP_DIV && r_bm == '0) begin
            n_job.status = ST_DIV_ZERO;
        end else if (r_op == OP_MUL || r_op == OP_DIV) begin
            n_job.neg  = r_sa != r_sb;
            n_job.nmag = r_p0;
        end else if (r_op == OP_ADD || r_op == OP_SUB) begin
            if (r_sa == w_yneg) begin
                n_job.neg  = r_sa;
                n_job.nmag = r_p0 + r_p1;
            end else if (r_p0 >= r_p1) begin
                n_job.neg  = r_sa;
                n_job.nmag = r_p0 - r_p1;
            end else begin
                n_job.neg  = w_yneg;
                n_job.nmag = r_p1 - r_p0;
            end
        end else begin
            if (r_sa != r_sb) n_job.lt = r_sa;
            else if (r_sa)    n_job.lt = r_p0 > r_p1;
            else              n_job.lt = r_p0 < r_p1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_OUT;
            S_OUT:  if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_job_valid = r_state == S_OUT;
    assign o_job       = r_job;

    `ASSERT_IMPL(a_accept_mul, i_clk, i_rst_n, (!o_busy && i_start) |=> (r_state == S_MUL), "accept did not start")
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (o_job_valid && !i_job_ready) |=> o_job_valid, "job dropped")
    `ASSERT_IMPL(a_mul_sum, i_clk, i_rst_n, (r_state == S_MUL) |=> (r_state == S_SUM), "stage skipped")
endmodule

// ----- design/rau_queue.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic job queue
// Two-entry queue between front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rau_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    input  rau_pkg::t_job i_wr_job,
    output logic          o_wr_ready,
    output logic          o_rd_valid,
    output rau_pkg::t_job o_rd_job,
    input  logic          i_rd_ready
);
    import rau_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = r_cnt != 2'd2;
    assign o_rd_valid = r_cnt != 2'd0;
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;
    assign o_rd_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_wr_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3, "queue count overflow")
    `ASSERT_IMPL(a_ptr_match, i_clk, i_rst_n, (r_cnt == 2'd0) |-> (r_wp == r_rp), "empty pointers differ")
    `ASSERT_IMPL(a_full_ptr, i_clk, i_rst_n, (r_cnt == 2'd2) |-> (r_wp == r_rp), "full pointers differ")
endmodule

// ----- design/rau_back.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic back end
// Reduces a fraction by its gcd: binary gcd, then two shared restoring divides.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rau_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  rau_pkg::t_job      i_job,
    output logic               o_job_ready,
    output logic               o_done,
    output rau_pkg::t_out_item o_result
);
    import rau_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_DIVN = 3'd3;
    localparam logic [2:0] S_DIVD = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam int CW = $clog2(MAG_W);

    logic [2:0]       r_state;
    t_job             r_job;
    logic [MAG_W-1:0] r_u, r_v, r_g;
    logic [6:0]       r_k;
    logic [CW-1:0]    r_bit;
    logic [MAG_W-1:0] r_rem, r_quo, r_qn;
    logic             r_done;
    t_out_item        r_res;

    logic [MAG_W:0]   w_trial;
    logic [MAG_W-1:0] w_src;
    assign w_src   = (r_state == S_DIVN) ? r_job.nmag : r_job.dmag;
    assign w_trial = {r_rem, w_src[r_bit]} - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_u   <= i_job.nmag;
                    r_v   <= i_job.dmag;
                    r_k   <= '0;
                    r_state <= (i_job.nmag == '0 || i_job.dmag == '0) ? S_EMIT : S_GCD;
                end
                S_GCD: begin
                    priority if (r_u == r_v) begin
                        r_g   <= r_u << r_k;
                        r_state <= S_FIX;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 7'd1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u > r_v) begin
                        r_u <= (r_u - r_v) >> 1;
                    end else begin
                        r_v <= (r_v - r_u) >> 1;
                    end
                end
                S_FIX: begin
                    r_bit <= CW'(MAG_W - 1);
                    r_rem <= '0;
                    r_state <= S_DIVN;
                end
                S_DIVN, S_DIVD: begin
                    if (!w_trial[MAG_W]) begin
                        r_rem <= w_trial[MAG_W-1:0];
                        r_quo <= {r_quo[MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[MAG_W-2:0], w_src[r_bit]};
                        r_quo <= {r_quo[MAG_W-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_rem <= '0;
                        if (r_state == S_DIVN) begin
                            r_qn <= w_trial[MAG_W] ? {r_quo[MAG_W-2:0], 1'b0}
                                                   : {r_quo[MAG_W-2:0], 1'b1};
                            r_state <= S_DIVD;
                        end else begin
                            r_v <= w_trial[MAG_W] ? {r_quo[MAG_W-2:0], 1'b0}
                                                  : {r_quo[MAG_W-2:0], 1'b1};
                            r_u <= r_qn;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (r_job.nmag == '0 || r_job.dmag == '0) begin
                        r_res.res_num <= '0;
                        r_res.res_den <= DEN_W'(1);
                    end else begin
                        r_res.res_num <= r_job.neg ? (64'd0 - r_u) : r_u;
                        r_res.res_den <= r_v[DEN_W-1:0];
                    end
                    r_res.less_than <= r_job.lt;
                    r_res.status    <= r_job.status;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_job_ready = r_state == S_IDLE;
    assign o_done      = r_done;
    assign o_result    = r_res;

    `ASSERT_IMPL(a_done_after_emit, i_clk, i_rst_n, o_done |-> ($past(r_state) == S_EMIT), "stray result")
    `ASSERT_NEVER(a_gcd_zero, i_clk, i_rst_n, (r_state == S_GCD) && (r_u == '0 || r_v == '0), "zero gcd operand")
    `ASSERT_IMPL(a_divd_follow, i_clk, i_rst_n, (r_state == S_DIVN && r_bit == '0) |=> (r_state == S_DIVD), "divide order")
endmodule

// ----- design/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide or compare two signed fractions, reduced.
// ----------------------------------------------------------------------------
// Usage: drive i_item and raise i_start; the beat is taken at a rising edge
// where i_start is high and busy is low. The front end then holds busy
// high through its MUL, SUM and OUT states while it forms cross products and classifies the item.
// Each result appears on o_result with o_done high for exactly one cycle;
// the receiver cannot stall it.
// Zero results, compares and error cases skip the gcd and the divides;
// otherwise the back end runs a binary gcd on the 64-bit magnitudes, then
// two restoring divides, numerator first and denominator second. The
// single shared divider and the gcd loop in the back end set throughput.
// A two-entry queue lets the front end accept up to three further beats
// while the back end works; busy stays high while a job waits for the full queue.
// Reset (synchronous, active low) empties the queue and idles both ends.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rau_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_done,
    output rau_pkg::t_out_item o_result
);
    import rau_pkg::*;

    logic w_fv, w_fr, w_qv, w_qr;
    t_job w_fj, w_qj;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_start, .i_item,
        .o_busy(busy), .o_job_valid(w_fv), .o_job(w_fj), .i_job_ready(w_fr)
    );

    rau_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(w_fv), .i_wr_job(w_fj), .o_wr_ready(w_fr),
        .o_rd_valid(w_qv), .o_rd_job(w_qj), .i_rd_ready(w_qr)
    );

    rau_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_qv), .i_job(w_qj), .o_job_ready(w_qr),
        .o_done, .o_result
    );
endmodule
